>>> rtl/sfmb_pkg.sv
// sfmb_pkg: shared widths, register indexes and types for the mirrored symmetric fir
// used by the sequencer, the mac cells, the output stage and the top level
`default_nettype none

package sfmb_pkg;

    localparam int MAX_TAPS_DEF = 6;
    localparam int SAMPLE_W     = 16;
    localparam int PRE_W        = SAMPLE_W + 1;
    localparam int COEF_W       = 18;
    localparam int PROD_W       = COEF_W + PRE_W;
    localparam int ACC_W        = PROD_W + 3;
    localparam int FRAC_W       = 16;
    localparam int OUT_W        = 24;
    localparam int POS_W        = 16;
    localparam int TAPS_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = COEF_W;

    localparam logic [CFG_IDX_W-1:0] REG_ODD_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = 3'd2;

    localparam logic signed [COEF_W-1:0] COEF_0_RESET = 18'sh10000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [PRE_W-1:0]    pre_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [OUT_W-1:0]    out_t;

    // control that travels with each result down the cell row
    typedef struct packed {
        logic valid;
        logic last;
        logic short_err;
    } ctl_t;

endpackage

`default_nettype wire

>>> rtl/symmetric_fir_mirror_border.sv
// symmetric_fir_mirror_border: an accepted word passes the sequencer, one register per mac
// cell and the output register on its way to m_. throughput is one word per cycle while m_
// does not stall; a line_end word issues k results from its held window (one short_line
// result for a too-short line), and s_tready stays low while they enter the cell row.
// aresetn is synchronous: it clears the pipeline valids, the line counter and loads the
// config registers with their defaults; the sample window is left as it is.
`default_nettype none

module symmetric_fir_mirror_border #(
    parameter int MAX_TAPS = sfmb_pkg::MAX_TAPS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [sfmb_pkg::SAMPLE_W-1:0]      s_tdata,    // [15:0] sample
    input  wire logic                               s_tlast,    // line_end
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [sfmb_pkg::OUT_W-1:0]              m_tdata,    // [23:0] filtered
    output logic                                    m_tlast,    // last_of_line
    output logic                                    m_tuser,    // short_line
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [sfmb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [sfmb_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfmb_pkg::*;

    logic               odd_mode_reg;
    logic [TAPS_W-1:0]  tap_count_reg;
    coef_t              coef_reg [MAX_TAPS];
    logic               en;
    logic               cfg_we;

    acc_t               acc_stage [MAX_TAPS+1];
    pre_t               pre_stage [MAX_TAPS+1][MAX_TAPS];
    ctl_t               ctl_stage [MAX_TAPS+1];
    out_t               out_value;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            odd_mode_reg  <= 1'b0;
            tap_count_reg <= TAPS_W'(1);
            for (int i = 0; i < MAX_TAPS; i++) begin
                coef_reg[i] <= (i == 0) ? COEF_0_RESET : '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ODD_MODE: begin
                    odd_mode_reg <= cfg_data[0];
                end
                REG_TAP_COUNT: begin
                    tap_count_reg <= cfg_data[TAPS_W-1:0];
                end
                default: begin
                    for (int i = 0; i < MAX_TAPS; i++) begin
                        if (cfg_index == REG_COEF_0 + CFG_IDX_W'(i)) begin
                            coef_reg[i] <= coef_t'(cfg_data);
                        end
                    end
                end
            endcase
        end
    end

    // the whole row moves whenever the output register can take a word
    assign en = !m_tvalid || m_tready;

    sfmb_seq #(
        .MAX_TAPS (MAX_TAPS)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_sample   (sample_t'(s_tdata)),
        .in_line_end (s_tlast),
        .odd_mode    (odd_mode_reg),
        .tap_count   (tap_count_reg),
        .pre_out     (pre_stage[0]),
        .ctl_out     (ctl_stage[0])
    );

    assign acc_stage[0] = '0;

    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        sfmb_cell #(
            .MAX_TAPS (MAX_TAPS),
            .TAP_IDX  (g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .coef    (coef_reg[g]),
            .acc_in  (acc_stage[g]),
            .pre_in  (pre_stage[g]),
            .ctl_in  (ctl_stage[g]),
            .acc_out (acc_stage[g+1]),
            .pre_out (pre_stage[g+1]),
            .ctl_out (ctl_stage[g+1])
        );
    end

    sfmb_out u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .acc_in  (acc_stage[MAX_TAPS]),
        .ctl_in  (ctl_stage[MAX_TAPS]),
        .m_valid (m_tvalid),
        .m_value (out_value),
        .m_last  (m_tlast),
        .m_short (m_tuser)
    );

    assign m_tdata = out_value;

endmodule

`default_nettype wire

>>> rtl/sfmb_seq.sv
// sfmb_seq: sample window, line counter and result sequencer with mirror operand selection
// depends on sfmb_pkg; feeds the pre-added tap operands into the first mac cell
`default_nettype none

module sfmb_seq #(
    parameter int MAX_TAPS = sfmb_pkg::MAX_TAPS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire sfmb_pkg::sample_t              in_sample,
    input  wire logic                           in_line_end,
    input  wire logic                           odd_mode,
    input  wire logic [sfmb_pkg::TAPS_W-1:0]    tap_count,
    output sfmb_pkg::pre_t                      pre_out [MAX_TAPS],
    output sfmb_pkg::ctl_t                      ctl_out
);
    import sfmb_pkg::*;

    localparam int WIN = 2 * MAX_TAPS - 1;
    localparam int WAW = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int IW  = WAW + 1;
    localparam int RW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;

    sample_t            win_reg [WIN];
    logic [POS_W-1:0]   pos_reg;
    logic               gen_valid_reg;
    logic               gen_flush_reg;
    logic               gen_short_reg;
    logic [RW-1:0]      gen_r_reg;
    logic [WAW-1:0]     gen_cm1_reg;
    pre_t               pre_reg [MAX_TAPS];
    pre_t               pre_next [MAX_TAPS];
    ctl_t               ctl_reg;

    logic [POS_W-1:0]   cnt;
    logic [POS_W-1:0]   cnt_m1;
    logic [WAW-1:0]     cm1;
    logic [TAPS_W-1:0]  k_eff;
    logic [TAPS_W:0]    k_x2m2;
    logic               too_short;
    logic               have_out;
    logic               gen_more;
    logic               accept;

    always_comb begin
        if (tap_count == '0) begin
            k_eff = TAPS_W'(1);
        end else if (tap_count > TAPS_W'(MAX_TAPS)) begin
            k_eff = TAPS_W'(MAX_TAPS);
        end else begin
            k_eff = tap_count;
        end
    end

    assign cnt       = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;
    assign cnt_m1    = cnt - 1'b1;
    assign cm1       = (cnt_m1 > POS_W'(WIN - 1)) ? WAW'(WIN - 1) : cnt_m1[WAW-1:0];
    assign k_x2m2    = {k_eff, 1'b0} - (TAPS_W+1)'(2);
    assign too_short = (cnt < POS_W'(k_eff)) || (cnt < POS_W'(k_x2m2));
    assign have_out  = (cnt >= POS_W'(k_eff));
    assign gen_more  = gen_flush_reg && (gen_r_reg != '0);
    assign in_ready  = en && (!gen_valid_reg || !gen_more);
    assign accept    = in_valid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            gen_valid_reg <= 1'b0;
            gen_flush_reg <= 1'b0;
            gen_short_reg <= 1'b0;
        end else if (accept) begin
            pos_reg       <= in_line_end ? '0 : cnt;
            gen_valid_reg <= in_line_end || have_out;
            gen_flush_reg <= in_line_end && !too_short;
            gen_short_reg <= in_line_end && too_short;
        end else if (en && gen_valid_reg && !gen_more) begin
            gen_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gen_r_reg   <= RW'(k_eff - 1'b1);
            gen_cm1_reg <= cm1;
            win_reg[0]  <= in_sample;
            for (int i = 1; i < WIN; i++) begin
                win_reg[i] <= win_reg[i-1];
            end
        end else if (en && gen_valid_reg && gen_more) begin
            gen_r_reg <= gen_r_reg - 1'b1;
        end
    end

    // operand pair per tap; r is the distance of the center from the newest sample
    always_comb begin
        logic [IW-1:0] r_ext;
        logic [IW-1:0] cm_ext;
        logic [IW-1:0] sum_ri;
        logic [IW-1:0] dl;
        logic [IW-1:0] dr;
        pre_t          a;
        pre_t          b;
        r_ext  = IW'(gen_r_reg);
        cm_ext = IW'(gen_cm1_reg);
        for (int i = 0; i < MAX_TAPS; i++) begin
            sum_ri = r_ext + IW'(i);
            // right side folds back past the newest sample
            dr = (r_ext >= IW'(i)) ? r_ext - IW'(i) : IW'(i) - r_ext;
            // left side folds back past the line start
            dl = (cm_ext >= sum_ri) ? sum_ri : (cm_ext << 1) - sum_ri;
            a  = pre_t'(win_reg[dl[WAW-1:0]]);
            b  = pre_t'(win_reg[dr[WAW-1:0]]);
            if (gen_short_reg || (i >= int'(k_eff))) begin
                pre_next[i] = '0;
            end else if (i == 0) begin
                pre_next[i] = odd_mode ? '0 : a;
            end else begin
                pre_next[i] = odd_mode ? a - b : a + b;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg.valid     <= gen_valid_reg;
            ctl_reg.last      <= gen_short_reg || (gen_flush_reg && (gen_r_reg == '0));
            ctl_reg.short_err <= gen_short_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                pre_reg[i] <= pre_next[i];
            end
        end
    end

    assign pre_out = pre_reg;
    assign ctl_out = ctl_reg;

endmodule

`default_nettype wire

>>> rtl/sfmb_cell.sv
// sfmb_cell: one tap of the filter row, multiplies its operand by its coefficient
// and adds to the running sum from the previous cell; depends on sfmb_pkg
`default_nettype none

module sfmb_cell #(
    parameter int MAX_TAPS = sfmb_pkg::MAX_TAPS_DEF,
    parameter int TAP_IDX  = 0
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               en,
    input  wire sfmb_pkg::coef_t    coef,
    input  wire sfmb_pkg::acc_t     acc_in,
    input  wire sfmb_pkg::pre_t     pre_in [MAX_TAPS],
    input  wire sfmb_pkg::ctl_t     ctl_in,
    output sfmb_pkg::acc_t          acc_out,
    output sfmb_pkg::pre_t          pre_out [MAX_TAPS],
    output sfmb_pkg::ctl_t          ctl_out
);
    import sfmb_pkg::*;

    logic signed [PROD_W-1:0] prod;
    acc_t                     acc_reg;
    acc_t                     acc_next;
    pre_t                     pre_reg [MAX_TAPS];
    ctl_t                     ctl_reg;

    assign prod     = coef * pre_in[TAP_IDX];
    assign acc_next = acc_in + ACC_W'(prod);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else if (en) begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= acc_next;
            for (int i = 0; i < MAX_TAPS; i++) begin
                pre_reg[i] <= pre_in[i];
            end
        end
    end

    assign acc_out = acc_reg;
    assign pre_out = pre_reg;
    assign ctl_out = ctl_reg;

endmodule

`default_nettype wire

>>> rtl/sfmb_out.sv
// sfmb_out: rounding, saturation and the output register of the result stream
// depends on sfmb_pkg; takes the sum from the last mac cell
`default_nettype none

module sfmb_out (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire sfmb_pkg::acc_t             acc_in,
    input  wire sfmb_pkg::ctl_t             ctl_in,
    output logic                            m_valid,
    output sfmb_pkg::out_t                  m_value,
    output logic                            m_last,
    output logic                            m_short
);
    import sfmb_pkg::*;

    localparam int QW = ACC_W + 1 - FRAC_W;
    localparam logic signed [OUT_W:0] Q_MAX = (OUT_W+1)'((2 ** (OUT_W - 1)) - 1);
    localparam logic signed [OUT_W:0] Q_MIN = -(OUT_W+1)'(2 ** (OUT_W - 1));

    logic signed [ACC_W:0] rounded;
    logic signed [QW-1:0]  q;
    out_t                  sat;
    logic                  valid_reg;
    out_t                  value_reg;
    logic                  last_reg;
    logic                  short_reg;

    // add half an lsb, then floor
    assign rounded = (ACC_W+1)'(acc_in) + (ACC_W+1)'(2 ** (FRAC_W - 1));
    assign q       = rounded[ACC_W:FRAC_W];

    always_comb begin
        if (q > Q_MAX) begin
            sat = Q_MAX[OUT_W-1:0];
        end else if (q < Q_MIN) begin
            sat = Q_MIN[OUT_W-1:0];
        end else begin
            sat = out_t'(q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= ctl_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= sat;
            last_reg  <= ctl_in.last;
            short_reg <= ctl_in.short_err;
        end
    end

    assign m_valid = valid_reg;
    assign m_value = value_reg;
    assign m_last  = last_reg;
    assign m_short = short_reg;

endmodule

`default_nettype wire

>>> tb/symmetric_fir_mirror_border_tb.sv
// symmetric_fir_mirror_border_tb: self-checking bench for the mirrored-border symmetric fir
// streams sample lines and register writes, predicts each filtered word and checks m_ in order
// depends on sfmb_pkg and symmetric_fir_mirror_border

module symmetric_fir_mirror_border_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sfmb_pkg::*;

    localparam int TAPS           = MAX_TAPS_DEF;
    localparam int WIN_DEPTH      = 2 * TAPS - 1;
    localparam int POS_MAX        = 65535;
    localparam int LATENCY        = TAPS + 2;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        out_t filtered;
        logic last;
        logic too_short;
    } fir_word_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // filter state as the block should hold it
    logic              fir_odd;
    logic [TAPS_W-1:0] fir_taps;
    coef_t             fir_coef [TAPS];
    sample_t           fir_window [WIN_DEPTH];
    int                fir_pos;

    fir_word_t expected_words[$];
    fir_word_t want_word;

    int mismatches;
    int words_checked;
    int samples_sent;
    int lines_sent;
    int reg_writes;
    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold;
    int stall_cycles;

    symmetric_fir_mirror_border dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- filter prediction

    function automatic void clear_filter_state();
        fir_odd  = 1'b0;
        fir_taps = TAPS_W'(1);
        foreach (fir_coef[i]) fir_coef[i] = '0;
        fir_coef[0] = COEF_0_RESET;
        foreach (fir_window[i]) fir_window[i] = '0;
        fir_pos = 0;
    endfunction

    function automatic void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_ODD_MODE: begin
                fir_odd = val[0];
            end
            REG_TAP_COUNT: begin
                fir_taps = val[TAPS_W-1:0];
            end
            default: begin
                fir_coef[int'(idx) - int'(REG_COEF_0)] = coef_t'(val);
            end
        endcase
    endfunction

    function automatic int active_taps();
        int k;
        k = int'(fir_taps);
        if (k < 1) k = 1;
        if (k > TAPS) k = TAPS;
        return k;
    endfunction

    // sample at line index j with mirrored borders, cnt samples of the line known
    function automatic longint mirrored_sample(int j, int cnt);
        int d;
        if (j < 0) j = -j;
        if (j > cnt - 1) j = 2 * (cnt - 1) - j;
        d = cnt - 1 - j;
        if (d < 0 || d >= WIN_DEPTH) return 0;
        return longint'(fir_window[d]);
    endfunction

    function automatic out_t filtered_at(int p, int cnt, int k);
        longint acc;
        longint a;
        longint b;
        longint q;
        acc = 0;
        if (!fir_odd) acc = longint'(fir_coef[0]) * mirrored_sample(p, cnt);
        for (int i = 1; i < k; i++) begin
            a = mirrored_sample(p - i, cnt);
            b = mirrored_sample(p + i, cnt);
            acc += longint'(fir_coef[i]) * (fir_odd ? a - b : a + b);
        end
        // round half up, floor shift
        q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (q > 64'sd8388607) q = 64'sd8388607;
        if (q < -64'sd8388608) q = -64'sd8388608;
        return out_t'(q[OUT_W-1:0]);
    endfunction

    function automatic void filter_sample(sample_t x, logic line_end);
        int k;
        int cnt;
        k = active_taps();
        for (int i = WIN_DEPTH - 1; i > 0; i--) fir_window[i] = fir_window[i-1];
        fir_window[0] = x;
        if (fir_pos < POS_MAX) fir_pos++;
        cnt = fir_pos;
        if (!line_end) begin
            if (cnt >= k) expected_words.push_back('{filtered_at(cnt - k, cnt, k), 1'b0, 1'b0});
            return;
        end
        fir_pos = 0;
        if (cnt < k || cnt < 2 * k - 2) begin
            expected_words.push_back('{out_t'(0), 1'b1, 1'b1});
            return;
        end
        // line end flushes the last k positions
        for (int p = cnt - k; p < cnt; p++)
            expected_words.push_back('{filtered_at(p, cnt, k), p == cnt - 1, 1'b0});
    endfunction

    // ---------------------------------------------------------------- drivers

    // all driving tasks are entered and left at a falling edge
    task automatic send_sample(sample_t x, logic line_end);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = x;
        s_tlast  = line_end;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filter_sample(x, line_end);
        samples_sent++;
        if (line_end) lines_sent++;
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        // a word without a result may still be in flight
        repeat (LATENCY + 4) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        load_register(idx, val);
        reg_writes++;
        @(negedge aclk);
    endtask

    task automatic program_filter(logic odd, logic [TAPS_W-1:0] taps, coef_t c [TAPS]);
        drain();
        write_reg(REG_ODD_MODE, CFG_DATA_W'(odd));
        write_reg(REG_TAP_COUNT, CFG_DATA_W'(taps));
        for (int i = 0; i < TAPS; i++) write_reg(REG_COEF_0 + CFG_IDX_W'(i), c[i]);
        cfg_valid = 1'b0;
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(9))
            0: return sample_t'(16'h7FFF);
            1: return sample_t'(16'h8000);
            2, 3: return sample_t'(int'($urandom_range(128)) - 64);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic coef_t rand_coef();
        case ($urandom_range(7))
            0: return coef_t'(18'h1FFFF);
            1: return coef_t'(18'h20000);
            2: return '0;
            3: return coef_t'(int'($urandom_range(2048)) - 1024);
            default: return coef_t'($urandom);
        endcase
    endfunction

    task automatic random_program(int min_taps, int max_taps);
        coef_t c [TAPS];
        logic [TAPS_W-1:0] taps;
        foreach (c[i]) c[i] = rand_coef();
        taps = TAPS_W'($urandom_range(max_taps, min_taps));
        // out-of-range tap counts now and then
        if (min_taps == 1 && max_taps == TAPS && $urandom_range(7) == 0)
            taps = $urandom_range(1) ? TAPS_W'(0) : TAPS_W'(7);
        program_filter(1'($urandom_range(1)), taps, c);
    endtask

    task automatic send_line(int n);
        for (int i = 0; i < n; i++) send_sample(rand_sample(), i == n - 1);
    endtask

    task automatic send_random_line();
        int k;
        int n;
        k = active_taps();
        case ($urandom_range(9))
            0: n = $urandom_range(2 * k, 1);                       // often too short
            1: n = $urandom_range(60, 20);
            default: n = $urandom_range(2 * k + 12, (2 * k - 2 > k) ? 2 * k - 2 : k);
        endcase
        send_line(n);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        coef_t c [TAPS];
        // reset config: single tap, unity gain
        send_sample(sample_t'(16'h7FFF), 1'b0);
        send_sample(sample_t'(16'h8000), 1'b0);
        send_sample('0, 1'b0);
        send_sample(sample_t'(-1), 1'b1);
        // odd kernel, full length, extreme coefficients
        c = '{coef_t'(18'h1FFFF), coef_t'(18'h20000), coef_t'(18'h1FFFF),
              coef_t'(18'h20000), coef_t'(18'h1FFFF), coef_t'(18'h20000)};
        program_filter(1'b1, TAPS_W'(TAPS), c);
        for (int i = 0; i < 2 * TAPS - 2; i++)
            send_sample((i % 2) ? sample_t'(16'h8000) : sample_t'(16'h7FFF), i == 2 * TAPS - 3);
        send_line(TAPS - 2);                                       // fewer samples than taps
        // tap count above the maximum, line between k and 2k-2
        c = '{coef_t'(18'h20000), coef_t'(18'h1FFFF), coef_t'(18'h20000),
              coef_t'(18'h1FFFF), coef_t'(18'h20000), coef_t'(18'h1FFFF)};
        program_filter(1'b0, TAPS_W'(7), c);
        for (int i = 0; i < 2 * TAPS - 4; i++)
            send_sample((i % 3) ? sample_t'(16'h8000) : sample_t'(16'h7FFF), i == 2 * TAPS - 5);
        // tap count zero acts as one, single-sample line
        program_filter(1'b0, TAPS_W'(0), c);
        send_sample(sample_t'(16'h8000), 1'b1);
    endtask

    task automatic test_random_lines(int budget);
        int target;
        target = samples_sent + budget;
        while (samples_sent < target) begin
            random_program(1, TAPS);
            repeat ($urandom_range(4, 1)) send_random_line();
        end
    endtask

    // registers change while a line is half done
    task automatic test_config_mid_line();
        int n;
        repeat (4) begin
            random_program(1, TAPS);
            n = $urandom_range(15, 1);
            for (int i = 0; i < n; i++) send_sample(rand_sample(), 1'b0);
            random_program(1, TAPS);
            send_line($urandom_range(16, 1));
        end
    endtask

    task automatic test_backpressure();
        random_program(TAPS, TAPS);
        sink_hold = HOLD_CYCLES;
        repeat (3) send_line(20);
        drain();
    endtask

    // ---------------------------------------------------------------- result side

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold > 0) begin
                m_tready = 1'b0;
                sink_hold--;
            end else begin
                m_tready = ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            words_checked++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected word: filtered=%0d last=%b short=%b",
                             $signed(m_tdata), m_tlast, m_tuser);
            end else begin
                want_word = expected_words.pop_front();
                if (m_tdata !== want_word.filtered || m_tlast !== want_word.last ||
                    m_tuser !== want_word.too_short) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("word %0d: expected filtered=%0d last=%b short=%b, got %0d %b %b",
                                 words_checked, want_word.filtered, want_word.last,
                                 want_word.too_short, $signed(m_tdata), m_tlast, m_tuser);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles with no word moving, %0d words outstanding",
                     stall_cycles, expected_words.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_ODD_MODE;
        cfg_data      = '0;
        mismatches    = 0;
        words_checked = 0;
        samples_sent  = 0;
        lines_sent    = 0;
        reg_writes    = 0;
        sink_hold     = 0;
        stall_cycles  = 0;
        src_idle_pct  = 7;
        sink_idle_pct = 55;
        clear_filter_state();
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random_lines(100);

        src_idle_pct  = 55;
        sink_idle_pct = 7;
        test_config_mid_line();
        test_backpressure();
        test_random_lines(80);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_lines(80);
        drain();

        $display("covered %0d lines / %0d samples over %0d register writes, both kernel modes,",
                 lines_sent, samples_sent, reg_writes);
        $display("short lines, mid-line reconfiguration and stalls on both sides;"
                 , " %0d words checked, %0d mismatches", words_checked, mismatches);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
